FILE: hdl/ftm_pkg.sv
// shared types and constants of the feature track matcher
package ftm_pkg;

  localparam int MaxTracksDef  = 32;
  localparam int FeatureDimDef = 512;

  localparam int AccW    = 42;
  localparam int AccHalf = 21;
  localparam int ProdW   = 67;
  localparam int QDepth  = 2;

  localparam logic [AccW-1:0] AccMax  = {AccW{1'b1}};
  localparam logic [12:0]     GateCap = 13'd8191;

  localparam logic [11:0] GateRst  = 12'd100;
  localparam logic [15:0] ThrRst   = 16'd3277;
  localparam logic [15:0] MaxAgeRst = 16'd100;

  // configuration register indexes
  localparam logic [1:0] CfgGate   = 2'd0;
  localparam logic [1:0] CfgThr    = 2'd1;
  localparam logic [1:0] CfgMaxAge = 2'd2;

  typedef enum logic [1:0] {
    K_FEAT = 2'd0,
    K_LAST = 2'd1,
    K_EOF  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] feat;
  } item_t;

  typedef struct packed {
    logic [11:0] gate;
    logic [15:0] thr;
    logic [15:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] seen;
    logic [11:0] x;
    logic [11:0] y;
  } entry_t;

endpackage

FILE: hdl/ftm_front.sv
// front end: classifies incoming requests and queues them for the back end
module ftm_front import ftm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [11:0] x_center_i,
  input  logic [11:0] y_center_i,
  input  logic [15:0] feature_value_i,
  input  logic        last_element_i,
  output item_t       q_item_o,
  output logic        q_valid_o,
  input  logic        q_pop_i
);

  localparam int QAW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCW = $clog2(QDepth + 1);

  item_t          q_mem [QDepth];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push, pop;
  item_t          cls;

  // classify the request
  always_comb begin
    cls.x    = x_center_i;
    cls.y    = y_center_i;
    cls.feat = feature_value_i;
    if (cmd_i) begin
      cls.kind = K_EOF;
    end else if (last_element_i) begin
      cls.kind = K_LAST;
    end else begin
      cls.kind = K_FEAT;
    end
  end

  assign in_stall_o = (cnt_q == QCW'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = q_mem[rd_q];

  // queue pointers
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QAW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QAW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule

FILE: hdl/ftm_back.sv
// back end: accumulation, association decision, feature copy and aging
module ftm_back import ftm_pkg::*; #(
  parameter int MAX_TRACKS  = MaxTracksDef,
  parameter int FEATURE_DIM = FeatureDimDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       q_item_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] track_id_o,
  output logic        new_track_o,
  output logic        table_full_o
);

  localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int IW  = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
  localparam int CW  = $clog2(FEATURE_DIM + 1);
  localparam int SD  = MAX_TRACKS * FEATURE_DIM;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_ACC      = 16'h0002,
    S_DEC_INIT = 16'h0004,
    S_DEC_RD   = 16'h0008,
    S_DEC_M1   = 16'h0010,
    S_DEC_M2   = 16'h0020,
    S_DEC_M3   = 16'h0040,
    S_DEC_M4   = 16'h0080,
    S_DEC_M5   = 16'h0100,
    S_DEC_END  = 16'h0200,
    S_COPY     = 16'h0400,
    S_MOD      = 16'h0800,
    S_MOD_END  = 16'h1000,
    S_AGE_RD   = 16'h2000,
    S_AGE_CHK  = 16'h4000,
    S_FRAME    = 16'h8000
  } state_e;

  function automatic logic [SAW-1:0] sf_addr(input logic [TW-1:0] t, input logic [IW-1:0] i);
    sf_addr = SAW'(t) * SAW'(FEATURE_DIM) + SAW'(i);
  endfunction

  // memories
  logic [15:0]     sf_mem  [SD];
  logic [15:0]     in_mem  [FEATURE_DIM];
  logic [AccW-1:0] acc_mem [MAX_TRACKS];
  entry_t          ent_mem [MAX_TRACKS];

  logic            sf_we, sf_re, in_we, in_re, acc_we, acc_re, ent_we, ent_re;
  logic [SAW-1:0]  sf_waddr, sf_raddr;
  logic [15:0]     sf_wdata, sf_rd_q, in_rd_q;
  logic [IW-1:0]   in_waddr, in_raddr;
  logic [TW-1:0]   acc_waddr, acc_raddr, ent_waddr, ent_raddr;
  logic [AccW-1:0] acc_wdata, acc_rd_q;
  entry_t          ent_wdata, ent_rd_q;

  // control and datapath registers
  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [31:0]      frame_q, frame_d;
  logic [15:0]      next_id_q, next_id_d;
  logic [MAX_TRACKS-1:0] valid_q, valid_d;
  logic [TW-1:0]    t_q, t_d;
  logic             issue_q, issue_d, p1_q, p1_d, p2_q, p2_d;
  logic [TW-1:0]    p1t_q, p1t_d, p2t_q, p2t_d;
  logic [33:0]      sq_q, sq_d;
  logic [AccW-1:0]  acc2_q, acc2_d;
  logic [31:0]      thr2_q, thr2_d;
  logic             found_q, found_d, free_q, free_d;
  logic [ProdW-1:0] best_q, best_d;
  logic [TW-1:0]    best_t_q, best_t_d, free_t_q, free_t_d, tgt_q, tgt_d;
  logic [15:0]      best_id_q, best_id_d;
  logic [23:0]      dx2_q, dx2_d, dy2_q, dy2_d;
  logic [43:0]      glim_q, glim_d;
  logic             seen_q, seen_d, ok_q, ok_d;
  logic [24:0]      sp_q, sp_d;
  logic [25:0]      lim2_q, lim2_d;
  logic [45:0]      pl_q, pl_d, ph_q, ph_d;
  logic [IW-1:0]    cp_i_q, cp_i_d, cp_wi_q, cp_wi_d;
  logic             cp_issue_q, cp_issue_d, cp_p_q, cp_p_d;
  logic [15:0]      rem_q, rem_d;
  logic [4:0]       bit_q, bit_d;
  logic [31:0]      limit_q, limit_d;
  logic             out_valid_q, out_valid_d, new_q, new_d, full_q, full_d;
  logic [15:0]      id_q, id_d;

  // combinational helpers
  logic signed [16:0] diff;
  logic signed [33:0] dsq;
  logic [42:0]        acc_sum;
  logic signed [12:0] dx, dy;
  logic signed [25:0] dxs, dys;
  logic [31:0]        elapsed;
  logic [12:0]        lim;
  logic [ProdW-1:0]   prod;
  logic [16:0]        shifted;
  logic               t_last;

  assign t_last = (t_q == TW'(MAX_TRACKS - 1));

  always_comb begin
    diff    = $signed({item_q.feat[15], item_q.feat}) - $signed({sf_rd_q[15], sf_rd_q});
    dsq     = diff * diff;
    acc_sum = {1'b0, acc2_q} + {9'b0, sq_q};
    dx      = $signed({1'b0, item_q.x}) - $signed({1'b0, ent_rd_q.x});
    dy      = $signed({1'b0, item_q.y}) - $signed({1'b0, ent_rd_q.y});
    dxs     = dx * dx;
    dys     = dy * dy;
    elapsed = frame_q - ent_rd_q.seen;
    lim     = (glim_q > 44'(GateCap)) ? GateCap : glim_q[12:0];
    prod    = {ph_q, {AccHalf{1'b0}}} + {{AccHalf{1'b0}}, pl_q};
    shifted = {rem_q, frame_q[bit_q]};
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    frame_d     = frame_q;
    next_id_d   = next_id_q;
    valid_d     = valid_q;
    t_d         = t_q;
    issue_d     = issue_q;
    p1_d        = 1'b0;
    p1t_d       = p1t_q;
    p2_d        = 1'b0;
    p2t_d       = p2t_q;
    sq_d        = sq_q;
    acc2_d      = acc2_q;
    thr2_d      = thr2_q;
    found_d     = found_q;
    free_d      = free_q;
    best_d      = best_q;
    best_t_d    = best_t_q;
    best_id_d   = best_id_q;
    free_t_d    = free_t_q;
    tgt_d       = tgt_q;
    dx2_d       = dx2_q;
    dy2_d       = dy2_q;
    glim_d      = glim_q;
    seen_d      = seen_q;
    ok_d        = ok_q;
    sp_d        = sp_q;
    lim2_d      = lim2_q;
    pl_d        = pl_q;
    ph_d        = ph_q;
    cp_i_d      = cp_i_q;
    cp_wi_d     = cp_wi_q;
    cp_issue_d  = cp_issue_q;
    cp_p_d      = 1'b0;
    rem_d       = rem_q;
    bit_d       = bit_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && out_stall_i;
    new_d       = new_q;
    full_d      = full_q;
    id_d        = id_q;
    q_pop_o     = 1'b0;
    sf_we       = 1'b0;
    sf_waddr    = '0;
    sf_wdata    = in_rd_q;
    sf_re       = 1'b0;
    sf_raddr    = '0;
    in_we       = 1'b0;
    in_waddr    = idx_q[IW-1:0];
    in_re       = 1'b0;
    in_raddr    = cp_i_q;
    acc_we      = 1'b0;
    acc_waddr   = p2t_q;
    acc_wdata   = acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];
    acc_re      = 1'b0;
    acc_raddr   = t_q;
    ent_we      = 1'b0;
    ent_waddr   = tgt_q;
    ent_wdata   = ent_rd_q;
    ent_re      = 1'b0;
    ent_raddr   = t_q;

    case (state_q)
      // take the next request
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          if (q_item_i.kind == K_EOF) begin
            idx_d = '0;
            if (cfg_i.max_age == '0) begin
              state_d = S_FRAME;
            end else begin
              rem_d   = '0;
              bit_d   = 5'd31;
              state_d = S_MOD;
            end
          end else if (idx_q < CW'(FEATURE_DIM)) begin
            in_we   = 1'b1;
            in_waddr = idx_q[IW-1:0];
            t_d     = '0;
            issue_d = 1'b1;
            state_d = S_ACC;
          end else if (q_item_i.kind == K_LAST) begin
            state_d = S_DEC_INIT;
          end
        end
      end

      // walk all tracks: read, square the difference, accumulate
      S_ACC: begin
        if (issue_q) begin
          sf_re    = 1'b1;
          sf_raddr = sf_addr(t_q, idx_q[IW-1:0]);
          acc_re   = 1'b1;
          p1_d     = 1'b1;
          p1t_d    = t_q;
          if (t_last) begin
            issue_d = 1'b0;
          end else begin
            t_d = t_q + 1'b1;
          end
        end
        p2_d   = p1_q;
        p2t_d  = p1t_q;
        sq_d   = 34'(unsigned'(dsq));
        acc2_d = (idx_q == '0) ? '0 : acc_rd_q;
        acc_we = p2_q;
        if (!issue_q && !p1_q && !p2_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = (item_q.kind == K_LAST) ? S_DEC_INIT : S_IDLE;
        end
      end

      S_DEC_INIT: begin
        thr2_d  = cfg_i.thr * cfg_i.thr;
        found_d = 1'b0;
        free_d  = 1'b0;
        t_d     = '0;
        state_d = S_DEC_RD;
      end

      // read one track, or note the first free entry
      S_DEC_RD: begin
        if (valid_q[t_q]) begin
          ent_re  = 1'b1;
          acc_re  = 1'b1;
          state_d = S_DEC_M1;
        end else begin
          if (!free_q) begin
            free_d   = 1'b1;
            free_t_d = t_q;
          end
          if (t_last) begin
            state_d = S_DEC_END;
          end else begin
            t_d = t_q + 1'b1;
          end
        end
      end

      S_DEC_M1: begin
        dx2_d   = dxs[23:0];
        dy2_d   = dys[23:0];
        glim_d  = {32'b0, cfg_i.gate} * {12'b0, elapsed};
        seen_d  = (ent_rd_q.seen == frame_q);
        state_d = S_DEC_M2;
      end

      S_DEC_M2: begin
        sp_d    = {1'b0, dx2_q} + {1'b0, dy2_q};
        lim2_d  = lim * lim;
        state_d = S_DEC_M3;
      end

      S_DEC_M3: begin
        pl_d    = acc_rd_q[AccHalf-1:0] * sp_q;
        ok_d    = !seen_q && ({1'b0, sp_q} <= lim2_q) &&
                  (acc_rd_q < {{(AccW-32){1'b0}}, thr2_q});
        state_d = S_DEC_M4;
      end

      S_DEC_M4: begin
        ph_d    = acc_rd_q[AccW-1:AccHalf] * sp_q;
        state_d = S_DEC_M5;
      end

      // keep the least product, first one on a tie
      S_DEC_M5: begin
        if (ok_q && (!found_q || prod < best_q)) begin
          found_d   = 1'b1;
          best_d    = prod;
          best_t_d  = t_q;
          best_id_d = ent_rd_q.id;
        end
        if (t_last) begin
          state_d = S_DEC_END;
        end else begin
          t_d     = t_q + 1'b1;
          state_d = S_DEC_RD;
        end
      end

      // publish the result and update or allocate the entry unless the table is full
      S_DEC_END: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          idx_d       = '0;
          new_d       = 1'b0;
          full_d      = 1'b0;
          state_d     = S_COPY;
          if (found_q) begin
            id_d  = best_id_q;
            tgt_d = best_t_q;
          end else if (free_q) begin
            id_d              = next_id_q;
            new_d             = 1'b1;
            tgt_d             = free_t_q;
            next_id_d         = next_id_q + 1'b1;
            valid_d[free_t_q] = 1'b1;
          end else begin
            id_d    = '0;
            full_d  = 1'b1;
            state_d = S_IDLE;
          end
          if (found_q || free_q) begin
            ent_we         = 1'b1;
            ent_waddr      = found_q ? best_t_q : free_t_q;
            ent_wdata.id   = found_q ? best_id_q : next_id_q;
            ent_wdata.seen = frame_q;
            ent_wdata.x    = item_q.x;
            ent_wdata.y    = item_q.y;
            cp_i_d         = '0;
            cp_issue_d     = 1'b1;
          end
        end
      end

      // copy the incoming vector into the track's store
      S_COPY: begin
        if (cp_issue_q) begin
          in_re   = 1'b1;
          cp_p_d  = 1'b1;
          cp_wi_d = cp_i_q;
          if (cp_i_q == IW'(FEATURE_DIM - 1)) begin
            cp_issue_d = 1'b0;
          end else begin
            cp_i_d = cp_i_q + 1'b1;
          end
        end
        if (cp_p_q) begin
          sf_we    = 1'b1;
          sf_waddr = sf_addr(tgt_q, cp_wi_q);
        end
        if (!cp_issue_q && !cp_p_q) begin
          state_d = S_IDLE;
        end
      end

      // frame counter modulo max_age, one bit a cycle
      S_MOD: begin
        rem_d = (shifted >= {1'b0, cfg_i.max_age}) ?
                16'(shifted - {1'b0, cfg_i.max_age}) : shifted[15:0];
        if (bit_q == '0) begin
          state_d = S_MOD_END;
        end else begin
          bit_d = bit_q - 1'b1;
        end
      end

      S_MOD_END: begin
        if (rem_q == '0 && frame_q >= {16'b0, cfg_i.max_age}) begin
          limit_d = frame_q - {16'b0, cfg_i.max_age};
          t_d     = '0;
          state_d = S_AGE_RD;
        end else begin
          state_d = S_FRAME;
        end
      end

      // aging pass over the table
      S_AGE_RD: begin
        if (valid_q[t_q]) begin
          ent_re  = 1'b1;
          state_d = S_AGE_CHK;
        end else if (t_last) begin
          state_d = S_FRAME;
        end else begin
          t_d = t_q + 1'b1;
        end
      end

      S_AGE_CHK: begin
        if (ent_rd_q.seen < limit_q) begin
          valid_d[t_q] = 1'b0;
        end
        if (t_last) begin
          state_d = S_FRAME;
        end else begin
          t_d     = t_q + 1'b1;
          state_d = S_AGE_RD;
        end
      end

      S_FRAME: begin
        frame_d = frame_q + 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      frame_q     <= 32'd1;
      next_id_q   <= '0;
      valid_q     <= '0;
      issue_q     <= 1'b0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      cp_issue_q  <= 1'b0;
      cp_p_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      frame_q     <= frame_d;
      next_id_q   <= next_id_d;
      valid_q     <= valid_d;
      issue_q     <= issue_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      cp_issue_q  <= cp_issue_d;
      cp_p_q      <= cp_p_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    t_q       <= t_d;
    p1t_q     <= p1t_d;
    p2t_q     <= p2t_d;
    sq_q      <= sq_d;
    acc2_q    <= acc2_d;
    thr2_q    <= thr2_d;
    found_q   <= found_d;
    free_q    <= free_d;
    best_q    <= best_d;
    best_t_q  <= best_t_d;
    best_id_q <= best_id_d;
    free_t_q  <= free_t_d;
    tgt_q     <= tgt_d;
    dx2_q     <= dx2_d;
    dy2_q     <= dy2_d;
    glim_q    <= glim_d;
    seen_q    <= seen_d;
    ok_q      <= ok_d;
    sp_q      <= sp_d;
    lim2_q    <= lim2_d;
    pl_q      <= pl_d;
    ph_q      <= ph_d;
    cp_i_q    <= cp_i_d;
    cp_wi_q   <= cp_wi_d;
    rem_q     <= rem_d;
    bit_q     <= bit_d;
    limit_q   <= limit_d;
    new_q     <= new_d;
    full_q    <= full_d;
    id_q      <= id_d;
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (sf_we) begin
      sf_mem[sf_waddr] <= sf_wdata;
    end
    if (sf_re) begin
      sf_rd_q <= sf_mem[sf_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      in_mem[in_waddr] <= item_d.feat;
    end
    if (in_re) begin
      in_rd_q <= in_mem[in_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign track_id_o   = id_q;
  assign new_track_o  = new_q;
  assign table_full_o = full_q;

endmodule

FILE: hdl/feature_track_matcher.sv
// top level of the feature track matcher: configuration registers and the two halves
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    cmd, x/y centre, feature value, last flag
//  out      output     out_valid_o / out_stall_i  track id, new track, table full
//  cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// a feature element walks every track over the feature store port
// a last element adds set-up, the result and the copy of the incoming vector into the track
// store, plus a pass over every track entry, valid or free
// with the table full there is no copy: the last element adds set-up, the result and the track pass
// end of frame advances the frame counter, with max_age non-zero after a modulo step and an aging pass when due
// reset clears all control state; track entries start invalid, no clearing pass is run
// a stalled result holds the back end only when it has the next result; the front queue holds two requests
module feature_track_matcher import ftm_pkg::*; #(
  parameter int MAX_TRACKS  = MaxTracksDef,
  parameter int FEATURE_DIM = FeatureDimDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [11:0]        x_center_i,
  input  logic [11:0]        y_center_i,
  input  logic signed [15:0] feature_value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        track_id_o,
  output logic               new_track_o,
  output logic               table_full_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  cfg_t  cfg_q, cfg_d;
  item_t q_item;
  logic  q_valid, q_pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGate:   cfg_d.gate    = cfg_data_i[11:0];
        CfgThr:    cfg_d.thr     = cfg_data_i;
        CfgMaxAge: cfg_d.max_age = cfg_data_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate    <= GateRst;
      cfg_q.thr     <= ThrRst;
      cfg_q.max_age <= MaxAgeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ftm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .x_center_i      (x_center_i),
    .y_center_i      (y_center_i),
    .feature_value_i (feature_value_i),
    .last_element_i  (last_element_i),
    .q_item_o        (q_item),
    .q_valid_o       (q_valid),
    .q_pop_i         (q_pop)
  );

  ftm_back #(
    .MAX_TRACKS  (MAX_TRACKS),
    .FEATURE_DIM (FEATURE_DIM)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_item_i     (q_item),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .track_id_o   (track_id_o),
    .new_track_o  (new_track_o),
    .table_full_o (table_full_o)
  );

endmodule

FILE: test/ftm_assoc_check.sv
// request monitor, association predictor and result comparison for the track matcher
`timescale 1ns / 1ps

module ftm_assoc_check import ftm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [11:0] x_center_i,
  input  logic [11:0] y_center_i,
  input  logic [15:0] feature_value_i,
  input  logic        last_element_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [15:0] track_id_o,
  input  logic        new_track_o,
  input  logic        table_full_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          awaited_o
);

  localparam int Tracks = MaxTracksDef;
  localparam int Dim    = FeatureDimDef;

  typedef struct packed {
    logic [15:0] id;
    logic        fresh;
    logic        full;
  } assoc_t;

  // mirrored register and track state
  logic [11:0] gate_q;
  logic [15:0] thr_q;
  logic [15:0] age_q;
  logic [31:0] frame_no;
  logic [15:0] id_next;
  bit          live    [Tracks];
  logic [15:0] tid     [Tracks];
  logic [31:0] seen    [Tracks];
  logic [11:0] ex      [Tracks];
  logic [11:0] ey      [Tracks];
  logic [15:0] feat_store [Tracks][Dim];
  logic [15:0] feat_in [Dim];
  logic [41:0] dist_acc [Tracks];
  int          elem;
  assoc_t      awaited_ids [$];

  assign awaited_o = awaited_ids.size();

  // drop the detection in progress
  function automatic void clear_detection();
    for (int t = 0; t < Tracks; t++) dist_acc[t] = '0;
    elem = 0;
  endfunction

  // add one element's squared difference to every live track
  function automatic void add_element(logic [15:0] f);
    longint d;
    logic [63:0] a;
    if (elem >= Dim) return;
    feat_in[elem] = f;
    for (int t = 0; t < Tracks; t++) begin
      if (!live[t]) continue;
      d = longint'($signed(f)) - longint'($signed(feat_store[t][elem]));
      a = 64'(dist_acc[t]) + 64'(d * d);
      dist_acc[t] = (a > 64'(AccMax)) ? AccMax : a[41:0];
    end
    elem++;
  endfunction

  // gated nearest neighbour choice, then update or allocate
  function automatic assoc_t associate_detection(logic [11:0] x, logic [11:0] y);
    logic [63:0] thr2;
    logic [63:0] lim;
    logic [63:0] sp;
    logic [66:0] prod;
    logic [66:0] best;
    logic [31:0] elapsed;
    int          dx;
    int          dy;
    int          win;
    bit          found;
    assoc_t      r;
    thr2  = 64'(thr_q) * 64'(thr_q);
    found = 0;
    best  = '0;
    win   = 0;
    r     = '0;
    for (int t = 0; t < Tracks; t++) begin
      if (!live[t] || seen[t] == frame_no) continue;
      dx = int'(x) - int'(ex[t]);
      dy = int'(y) - int'(ey[t]);
      sp = 64'(dx * dx + dy * dy);
      elapsed = frame_no - seen[t];
      lim = 64'(gate_q) * 64'(elapsed);
      if (lim > 64'(GateCap)) lim = 64'(GateCap);
      if (sp > lim * lim) continue;
      if (64'(dist_acc[t]) >= thr2) continue;
      prod = 67'(dist_acc[t]) * 67'(sp);
      if (!found || prod < best) begin
        found = 1;
        best  = prod;
        win   = t;
      end
    end
    if (!found) begin
      win = Tracks;
      for (int t = Tracks - 1; t >= 0; t--) if (!live[t]) win = t;
      if (win == Tracks) begin
        r.full = 1'b1;
        return r;
      end
      live[win] = 1;
      tid[win]  = id_next;
      id_next   = id_next + 16'd1;
      r.fresh   = 1'b1;
    end
    for (int k = 0; k < Dim; k++) feat_store[win][k] = feat_in[k];
    seen[win] = frame_no;
    ex[win]   = x;
    ey[win]   = y;
    r.id      = tid[win];
    return r;
  endfunction

  // aging pass and frame advance
  function automatic void close_frame();
    if (age_q != 0 && frame_no % 32'(age_q) == 0 && frame_no >= 32'(age_q)) begin
      for (int t = 0; t < Tracks; t++)
        if (live[t] && seen[t] < frame_no - 32'(age_q)) live[t] = 0;
    end
    frame_no = frame_no + 32'd1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    assoc_t got;
    assoc_t want;
    if (!rst_ni) begin
      gate_q   = GateRst;
      thr_q    = ThrRst;
      age_q    = MaxAgeRst;
      frame_no = 32'd1;
      id_next  = '0;
      for (int t = 0; t < Tracks; t++) begin
        live[t] = 0;
        tid[t]  = '0;
        seen[t] = '0;
        ex[t]   = '0;
        ey[t]   = '0;
        for (int k = 0; k < Dim; k++) feat_store[t][k] = '0;
      end
      for (int k = 0; k < Dim; k++) feat_in[k] = '0;
      clear_detection();
      awaited_ids.delete();
      fail_count_o = 0;
    end else begin
      // compare a delivered result
      if (out_valid_o && !out_stall_i) begin
        got = '{track_id_o, new_track_o, table_full_o};
        if (awaited_ids.size() == 0) begin
          $error("unexpected result: track_id %0d new_track %0d table_full %0d",
                 got.id, got.fresh, got.full);
          fail_count_o++;
        end else begin
          want = awaited_ids.pop_front();
          if (got.id !== want.id) begin
            $error("track_id: expected %0d, got %0d", want.id, got.id);
            fail_count_o++;
          end
          if (got.fresh !== want.fresh) begin
            $error("new_track: expected %0d, got %0d", want.fresh, got.fresh);
            fail_count_o++;
          end
          if (got.full !== want.full) begin
            $error("table_full: expected %0d, got %0d", want.full, got.full);
            fail_count_o++;
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgGate:   gate_q = cfg_data_i[11:0];
          CfgThr:    thr_q  = cfg_data_i;
          CfgMaxAge: age_q  = cfg_data_i;
          default: ;
        endcase
      end
      // accepted request
      if (in_valid_i && !in_stall_o) begin
        if (cmd_i) begin
          clear_detection();
          close_frame();
        end else begin
          add_element(feature_value_i);
          if (last_element_i) begin
            awaited_ids.insert(awaited_ids.size(),
                               associate_detection(x_center_i, y_center_i));
            clear_detection();
          end
        end
      end
    end
  end

endmodule

FILE: test/tb.sv
// stimulus, reset, watchdog and verdict for the feature track matcher
`timescale 1ns / 1ps

module tb;
  import ftm_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int Settle    = 1000;
  localparam int PoolSize  = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [11:0] x_center_i = '0;
  logic [11:0] y_center_i = '0;
  logic [15:0] feature_value_i = '0;
  logic        last_element_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] track_id_o;
  logic        new_track_o;
  logic        table_full_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CfgGate;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          awaited;

  bit          idle_en = 1'b1;
  int          sent;
  int          quiet_cycles;
  logic [15:0] pool_feat [PoolSize][8];
  int          pool_len [PoolSize];
  logic [11:0] pool_x [PoolSize];
  logic [11:0] pool_y [PoolSize];
  int          pool_n;
  int          pool_wr;

  always #6 clk_i = ~clk_i;

  feature_track_matcher dut (.*);

  ftm_assoc_check u_check (
    .fail_count_o(fail_count),
    .awaited_o   (awaited),
    .*
  );

  // receiver stalls
  always @(negedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(99) < 23);
  end

  // watchdog on request and result progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request on the input channel
  task automatic put(logic c, logic [11:0] x, logic [11:0] y, logic [15:0] f, logic l);
    while (idle_en && $urandom_range(99) < 23) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    cmd_i           = c;
    x_center_i      = x;
    y_center_i      = y;
    feature_value_i = f;
    last_element_i  = l;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic end_frame();
    put(1'b1, 12'($urandom), 12'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // a detection, either fresh or a perturbed copy of a pooled one
  task automatic send_detection(int len, logic [11:0] x, logic [11:0] y, int src, int noise);
    logic [15:0] v;
    logic [15:0] keep [8];
    for (int k = 0; k < len; k++) begin
      if (src >= 0 && k < pool_len[src])
        v = pool_feat[src][k] + 16'($urandom_range(2 * noise)) - 16'(noise);
      else
        v = 16'($urandom);
      if (k < 8) keep[k] = v;
      put(1'b0, x, y, v, k == len - 1);
    end
    for (int k = 0; k < 8; k++) pool_feat[pool_wr][k] = (k < len) ? keep[k] : '0;
    pool_len[pool_wr] = (len > 8) ? 8 : len;
    pool_x[pool_wr]   = x;
    pool_y[pool_wr]   = y;
    pool_wr = (pool_wr + 1) % PoolSize;
    if (pool_n < PoolSize) pool_n++;
  endtask

  function automatic logic [11:0] nudge(logic [11:0] c, int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // hold off until every result is back and the block has gone quiet
  task automatic drain();
    in_valid_i = 1'b0;
    while (awaited != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  task automatic random_phase(int budget);
    int r;
    int src;
    int len;
    int stop_at;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        end_frame();
      end else if (r < 15) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++)
          put(1'b0, 12'($urandom), 12'($urandom), 16'($urandom), 1'b0);
        end_frame();
      end else if (r < 70 && pool_n > 0) begin
        src = $urandom_range(pool_n - 1);
        len = ($urandom_range(4) == 0) ? $urandom_range(1, 8) : pool_len[src];
        send_detection(len, nudge(pool_x[src], 150), nudge(pool_y[src], 150), src,
                       $urandom_range(300));
      end else begin
        send_detection($urandom_range(1, 8), 12'($urandom), 12'($urandom), -1, 0);
      end
    end
  endtask

  initial begin
    logic [11:0] ox;
    sent = 0;
    pool_n = 0;
    pool_wr = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // over-long detection fills the incoming buffer, then a rematch next frame
    send_detection(FeatureDimDef + 3, 12'd0, 12'd0, -1, 0);
    end_frame();
    send_detection(4, 12'd50, 12'd50, 0, 0);
    // same track already matched this frame, so a new one
    send_detection(4, 12'd50, 12'd50, 0, 0);
    // frame closed in the middle of a detection
    put(1'b0, 12'd7, 12'd9, 16'h7fff, 1'b0);
    put(1'b0, 12'd7, 12'd9, 16'h8000, 1'b0);
    end_frame();
    // field extremes
    put(1'b0, 12'd4095, 12'd0, 16'h8000, 1'b0);
    put(1'b0, 12'd4095, 12'd0, 16'h7fff, 1'b1);
    put(1'b0, 12'd0, 12'd4095, 16'h0000, 1'b1);
    end_frame();

    // default registers
    random_phase(50);
    drain();

    // widest gate and threshold, longest age, no idling at all
    idle_en = 1'b0;
    write_reg(CfgGate, 16'd4095);
    write_reg(CfgThr, 16'd65535);
    write_reg(CfgMaxAge, 16'd65535);
    random_phase(50);
    drain();
    idle_en = 1'b1;

    // nothing matches, aging every frame
    write_reg(CfgGate, 16'd0);
    write_reg(CfgThr, 16'd0);
    write_reg(CfgMaxAge, 16'd1);
    random_phase(35);
    drain();

    // tight random settings
    write_reg(CfgGate, 16'($urandom_range(1, 40)));
    write_reg(CfgThr, 16'($urandom_range(500, 5000)));
    write_reg(CfgMaxAge, 16'($urandom_range(2, 6)));
    random_phase(45);
    drain();

    // fully random settings
    write_reg(CfgGate, 16'($urandom_range(4095)));
    write_reg(CfgThr, 16'($urandom));
    write_reg(CfgMaxAge, 16'($urandom_range(1, 65535)));
    ox = 12'($urandom);
    send_detection(2, ox, ox, -1, 0);
    random_phase(40);

    drain();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: feature_track_matcher.f
hdl/ftm_pkg.sv
hdl/ftm_front.sv
hdl/ftm_back.sv
hdl/feature_track_matcher.sv
test/ftm_assoc_check.sv
test/tb.sv
